### hw/rtl/cartridge_bank_mapper_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cartridge bank mapper
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CBM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbm: property violated");
`define CBM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbm: property violated");
`else
`define CBM_ASSERT_IMP(lbl, ante, cons)
`define CBM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared widths, codes and pipeline record of the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

	localparam int ADDR_W      = 16;
	localparam int DATA_W      = 8;
	localparam int ROM_ADDR_W  = 21;
	localparam int SIZE_W      = 16;
	localparam int IDX_W       = 15;
	localparam int RECIP_W     = 16;
	localparam int RECIP_SHIFT = 15;
	localparam int ROM_OFS_W   = 14;
	localparam int RAM_OFS_W   = 13;
	localparam int ROM_BANK_W  = 7;
	localparam int RAM_BANK_W  = 2;

	typedef enum logic [1:0] {
		ST_ROM   = 2'd0,
		ST_RAM   = 2'd1,
		ST_WRITE = 2'd2,
		ST_ERROR = 2'd3
	} status_t;

	typedef enum logic {
		FUNC_READ  = 1'b0,
		FUNC_WRITE = 1'b1
	} func_t;

	typedef enum logic {
		MODE_ROM = 1'b0,
		MODE_RAM = 1'b1
	} bank_mode_t;

	// bus_address[15:13]
	typedef enum logic [2:0] {
		RG_RAM_EN  = 3'd0,
		RG_ROM_LO  = 3'd1,
		RG_BANK_HI = 3'd2,
		RG_MODE    = 3'd3,
		RG_EXT_RAM = 3'd5
	} region_t;

	localparam logic [3:0]        RAM_EN_KEY    = 4'hA;
	localparam logic [DATA_W-1:0] MODE_ROM_CODE = 8'h00;
	localparam logic [DATA_W-1:0] MODE_RAM_CODE = 8'h01;

	typedef struct packed {
		status_t                 status;
		logic                    ram_wr;
		logic [IDX_W-1:0]        idx;
		logic [DATA_W-1:0]       wdata;
		logic [ROM_ADDR_W-1:0]   rom_address;
	} stage_t;

endpackage

### hw/rtl/cbm_if.sv
// ----------------------------------------------------------------------------
// cbm_if
// Valid/ready channels of the cartridge bank mapper: bus access, result, config.
// ----------------------------------------------------------------------------
interface cbm_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] bus_address;
	logic [7:0]  write_value;

	modport source (output valid, func, bus_address, write_value, input ready);
	modport sink   (input valid, func, bus_address, write_value, output ready);
endinterface

interface cbm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [20:0] rom_address;
	logic [7:0]  read_data;

	modport source (output valid, status, rom_address, read_data, input ready);
	modport sink   (input valid, status, rom_address, read_data, output ready);
endinterface

interface cbm_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] ram_size_bytes;

	modport source (output valid, ram_size_bytes, input ready);
	modport sink   (input valid, ram_size_bytes, output ready);
endinterface

### hw/rtl/cbm_ctrl.sv
// ----------------------------------------------------------------------------
// cbm_ctrl
// Bank control registers and access decode into the first pipeline stage.
// ----------------------------------------------------------------------------
module cbm_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                accept,
	input  logic                                func,
	input  logic [cbm_pkg::ADDR_W-1:0]          bus_address,
	input  logic [cbm_pkg::DATA_W-1:0]          write_value,
	input  logic                                ram_present,
	output logic                                s1_valid,
	output cbm_pkg::stage_t                     s1
);

	logic [cbm_pkg::ROM_BANK_W-1:0] rom_bank_q, rom_bank_d;
	logic [cbm_pkg::RAM_BANK_W-1:0] ram_bank_q, ram_bank_d;
	logic                           ram_en_q, ram_en_d;
	cbm_pkg::bank_mode_t            mode_q, mode_d;
	cbm_pkg::region_t               region;
	cbm_pkg::stage_t                dec;
	logic                           ram_ok;

	always_comb begin
		region     = cbm_pkg::region_t'(bus_address[15:13]);
		rom_bank_d = rom_bank_q;
		ram_bank_d = ram_bank_q;
		ram_en_d   = ram_en_q;
		mode_d     = mode_q;
		ram_ok     = ram_present && ram_en_q;

		dec.status      = cbm_pkg::ST_ERROR;
		dec.ram_wr      = 1'b0;
		dec.idx         = {ram_bank_q, bus_address[cbm_pkg::RAM_OFS_W-1:0]};
		dec.wdata       = write_value;
		dec.rom_address = '0;

		if (func == cbm_pkg::FUNC_WRITE) begin
			dec.status = cbm_pkg::ST_WRITE;
			unique case (region)
				cbm_pkg::RG_RAM_EN: begin
					ram_en_d = (write_value[3:0] == cbm_pkg::RAM_EN_KEY);
				end
				cbm_pkg::RG_ROM_LO: begin
					rom_bank_d = {write_value[6:5],
						(write_value[4:0] == 5'd0) ? 5'd1 : write_value[4:0]};
				end
				cbm_pkg::RG_BANK_HI: begin
					if (mode_q == cbm_pkg::MODE_ROM) begin
						rom_bank_d = {write_value[1:0], rom_bank_q[4:0]};
					end else begin
						ram_bank_d = write_value[1:0];
					end
				end
				cbm_pkg::RG_MODE: begin
					if (write_value == cbm_pkg::MODE_ROM_CODE) begin
						mode_d = cbm_pkg::MODE_ROM;
					end else if (write_value == cbm_pkg::MODE_RAM_CODE) begin
						mode_d = cbm_pkg::MODE_RAM;
					end
				end
				cbm_pkg::RG_EXT_RAM: begin
					dec.ram_wr = ram_ok;
				end
				default: begin
				end
			endcase
		end else begin
			unique case (region) inside
				cbm_pkg::RG_RAM_EN, cbm_pkg::RG_ROM_LO: begin
					dec.status      = cbm_pkg::ST_ROM;
					dec.rom_address = cbm_pkg::ROM_ADDR_W'(bus_address);
				end
				cbm_pkg::RG_BANK_HI, cbm_pkg::RG_MODE: begin
					dec.status      = cbm_pkg::ST_ROM;
					dec.rom_address = {rom_bank_q, bus_address[cbm_pkg::ROM_OFS_W-1:0]};
				end
				cbm_pkg::RG_EXT_RAM: begin
					dec.status = ram_ok ? cbm_pkg::ST_RAM : cbm_pkg::ST_ERROR;
				end
				default: begin
					dec.status = cbm_pkg::ST_ERROR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q <= 7'd1;
			ram_bank_q <= '0;
			ram_en_q   <= 1'b0;
			mode_q     <= cbm_pkg::MODE_ROM;
			s1_valid   <= 1'b0;
		end else begin
			if (accept) begin
				rom_bank_q <= rom_bank_d;
				ram_bank_q <= ram_bank_d;
				ram_en_q   <= ram_en_d;
				mode_q     <= mode_d;
			end
			if (en) begin
				s1_valid <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1 <= dec;
		end
	end

endmodule

### hw/rtl/cbm_recip.sv
// ----------------------------------------------------------------------------
// cbm_recip
// Bit-serial divider computing floor(2^15 / size) after a size register write.
// ----------------------------------------------------------------------------
module cbm_recip #(
	parameter logic [15:0] RECIP_RST = 16'd1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cbm_pkg::SIZE_W-1:0]    divisor,
	output logic [cbm_pkg::RECIP_W-1:0]   recip,
	output logic                          busy
);

	localparam int CNT_W = $clog2(cbm_pkg::RECIP_SHIFT + 1);
	localparam int SW    = cbm_pkg::SIZE_W;

	logic [CNT_W-1:0]           cnt_q;
	logic [SW-1:0]              rem_q, rem_d;
	logic [SW-1:0]              div_q;
	logic [cbm_pkg::RECIP_W-1:0] recip_q;
	logic                       busy_q;
	logic [SW:0]                trial;
	logic                       qbit;
	logic                       nbit;

	// dividend is a single one in its top bit
	always_comb begin
		nbit  = (cnt_q == CNT_W'(cbm_pkg::RECIP_SHIFT));
		trial = {rem_q, nbit};
		qbit  = (trial >= {1'b0, div_q});
		rem_d = qbit ? SW'(trial - {1'b0, div_q}) : SW'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			rem_q   <= '0;
			div_q   <= '0;
			recip_q <= RECIP_RST;
		end else if (start) begin
			busy_q  <= 1'b1;
			cnt_q   <= CNT_W'(cbm_pkg::RECIP_SHIFT);
			rem_q   <= '0;
			div_q   <= divisor;
			recip_q <= '0;
		end else if (busy_q) begin
			rem_q   <= rem_d;
			recip_q <= {recip_q[cbm_pkg::RECIP_W-2:0], qbit};
			cnt_q   <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign recip = recip_q;
	assign busy  = busy_q;

endmodule

### hw/rtl/cbm_mod.sv
// ----------------------------------------------------------------------------
// cbm_mod
// Two-stage reduction of the RAM index modulo the installed size.
// ----------------------------------------------------------------------------
module cbm_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          s1_valid,
	input  cbm_pkg::stage_t               s1,
	input  logic [cbm_pkg::RECIP_W-1:0]   recip,
	input  logic [cbm_pkg::SIZE_W-1:0]    size,
	output logic                          s3_valid,
	output cbm_pkg::stage_t               s3,
	output logic [cbm_pkg::SIZE_W-1:0]    s3_ram_addr
);

	localparam int IW = cbm_pkg::IDX_W;
	localparam int SW = cbm_pkg::SIZE_W;
	localparam int PW = IW + cbm_pkg::RECIP_W;

	logic [PW-1:0]   quo_prod;
	logic [PW-1:0]   back_prod;
	logic            s2_valid;
	cbm_pkg::stage_t s2;
	logic [IW-1:0]   quo_s2;
	logic [SW-1:0]   rem_raw;
	logic [SW-1:0]   rem_s3;

	// quotient estimate is exact or one low
	assign quo_prod  = PW'(s1.idx) * PW'(recip);
	assign back_prod = PW'(quo_s2) * PW'(size);
	assign rem_raw   = SW'(s2.idx) - back_prod[SW-1:0];

	assign s3_ram_addr = (rem_s3 >= size) ? rem_s3 - size : rem_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
			s3_valid <= 1'b0;
		end else if (en) begin
			s2_valid <= s1_valid;
			s3_valid <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s2     <= s1;
			quo_s2 <= quo_prod[cbm_pkg::RECIP_SHIFT +: IW];
			s3     <= s2;
			rem_s3 <= rem_raw;
		end
	end

endmodule

### hw/rtl/cbm_ram.sv
// ----------------------------------------------------------------------------
// cbm_ram
// Cartridge RAM store, single port with registered read and post-reset clear.
// ----------------------------------------------------------------------------
module cbm_ram #(
	parameter int DEPTH = 32768
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            we,
	input  logic [$clog2(DEPTH)-1:0]        addr,
	input  logic [cbm_pkg::DATA_W-1:0]      wdata,
	output logic [cbm_pkg::DATA_W-1:0]      rdata,
	output logic                            clr_busy
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [cbm_pkg::DATA_W-1:0] mem [DEPTH];
	logic [cbm_pkg::DATA_W-1:0] rdata_q;
	logic [AW-1:0]              clr_q;
	logic                       clr_busy_q;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [cbm_pkg::DATA_W-1:0] wr_data;

	assign wr_en   = clr_busy_q || (en && we);
	assign wr_addr = clr_busy_q ? clr_q : addr;
	assign wr_data = clr_busy_q ? '0 : wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata    = rdata_q;
	assign clr_busy = clr_busy_q;

endmodule

### hw/rtl/cartridge_bank_mapper.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// ROM/RAM bank-switching mapper for one cartridge bus.
// ----------------------------------------------------------------------------
// req carries one CPU bus transaction (read or write); rsp returns exactly one
// result transaction per request, in order: status, translated ROM address for
// ROM reads, and the RAM byte for RAM reads. cfg writes the installed RAM size.
// Throughput: one transaction per cycle while req.ready is high; the pipeline
// holds up to four in flight (s1 to s4) plus the output register, and keeps
// filling while rsp stalls until a transaction reaches s4.
// After a size write, req.ready stays low while the bit-serial reciprocal
// unit recomputes 2^15/size for the index reduction multiplier.
// After reset, req.ready stays low while the RAM store is cleared one byte
// per cycle; cfg writes are taken during that pass.
// Reset sets ROM bank 1, RAM bank 0, RAM disabled, ROM mode, size 32768.
// If rsp stalls while s4 is valid, req.ready drops until rsp is ready.
// ----------------------------------------------------------------------------
`include "cartridge_bank_mapper_assert.svh"

module cartridge_bank_mapper #(
	parameter int RAM_DEPTH = 32768
) (
	input  logic       clk,
	input  logic       arst_n,
	cbm_req_if.sink    req,
	cbm_rsp_if.source  rsp,
	cbm_cfg_if.sink    cfg
);

	localparam int AW = $clog2(RAM_DEPTH);
	localparam int SW = cbm_pkg::SIZE_W;
	localparam logic [SW-1:0] DEPTH_S = SW'(RAM_DEPTH);
	localparam logic [cbm_pkg::RECIP_W-1:0] RECIP_RST =
		cbm_pkg::RECIP_W'((2 ** cbm_pkg::RECIP_SHIFT) / RAM_DEPTH);

	logic [SW-1:0]                   ram_size_q;
	logic [SW-1:0]                   eff_size;
	logic [SW-1:0]                   cfg_div;
	logic                            cfg_acc;
	logic [cbm_pkg::RECIP_W-1:0]     recip;
	logic                            recip_busy;
	logic                            clr_busy;
	logic                            pipe_en;
	logic                            req_acc;
	logic                            s1_valid;
	cbm_pkg::stage_t                 s1;
	logic                            s3_valid;
	cbm_pkg::stage_t                 s3;
	logic [SW-1:0]                   s3_ram_addr;
	logic                            s4_valid;
	cbm_pkg::stage_t                 s4;
	logic [cbm_pkg::DATA_W-1:0]      ram_rdata;
	logic                            out_valid_q;
	cbm_pkg::status_t                status_q;
	logic [cbm_pkg::ROM_ADDR_W-1:0]  rom_address_q;
	logic [cbm_pkg::DATA_W-1:0]      read_data_q;

	assign cfg.ready = 1'b1;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign cfg_div   = (cfg.ram_size_bytes > DEPTH_S) ? DEPTH_S : cfg.ram_size_bytes;
	assign eff_size  = (ram_size_q > DEPTH_S) ? DEPTH_S : ram_size_q;

	assign pipe_en   = !out_valid_q || rsp.ready || !s4_valid;
	assign req.ready = pipe_en && !clr_busy && !recip_busy && !cfg.valid;
	assign req_acc   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_size_q <= 16'd32768;
		end else if (cfg_acc) begin
			ram_size_q <= cfg.ram_size_bytes;
		end
	end

	cbm_recip #(
		.RECIP_RST (RECIP_RST)
	) u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cfg_acc),
		.divisor (cfg_div),
		.recip   (recip),
		.busy    (recip_busy)
	);

	cbm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (pipe_en),
		.accept      (req_acc),
		.func        (req.func),
		.bus_address (req.bus_address),
		.write_value (req.write_value),
		.ram_present (eff_size != '0),
		.s1_valid    (s1_valid),
		.s1          (s1)
	);

	cbm_mod u_mod (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (pipe_en),
		.s1_valid    (s1_valid),
		.s1          (s1),
		.recip       (recip),
		.size        (eff_size),
		.s3_valid    (s3_valid),
		.s3          (s3),
		.s3_ram_addr (s3_ram_addr)
	);

	cbm_ram #(
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.we       (s3_valid && s3.ram_wr),
		.addr     (s3_ram_addr[AW-1:0]),
		.wdata    (s3.wdata),
		.rdata    (ram_rdata),
		.clr_busy (clr_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s4_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pipe_en) begin
				s4_valid <= s3_valid;
			end
			if (pipe_en && s4_valid) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			s4 <= s3;
		end
		if (pipe_en && s4_valid) begin
			status_q      <= s4.status;
			rom_address_q <= s4.rom_address;
			read_data_q   <= (s4.status == cbm_pkg::ST_RAM) ? ram_rdata : '0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.rom_address = rom_address_q;
	assign rsp.read_data   = read_data_q;

	`CBM_ASSERT_IMP(a_busy_blocks_req, clr_busy || recip_busy, !req.ready)
	`CBM_ASSERT_IMP(a_ram_addr_in_size, s3_valid && (s3.status == cbm_pkg::ST_RAM || s3.ram_wr), s3_ram_addr < eff_size)
	`CBM_ASSERT_NXT(a_s4_reaches_out, pipe_en && s4_valid, rsp.valid)
	`CBM_ASSERT_IMP(a_data_only_on_ram, rsp.valid && rsp.status != cbm_pkg::ST_RAM, rsp.read_data == '0)

endmodule
